// ===== src/sfms_pkg.sv =====
// ----------------------------------------------------------------------------
// sfms_pkg
// Shared types and codes for the sparse field mask serializer: command and
// word-kind codes, request and response beats, mask store control.
// ----------------------------------------------------------------------------
package sfms_pkg;

   localparam int WORD_BITS = 32;

   // command codes
   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // serialized word kinds
   localparam logic [1:0] KIND_COUNT = 2'd0;
   localparam logic [1:0] KIND_MASK  = 2'd1;
   localparam logic [1:0] KIND_VALUE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [10:0] field_index;
      logic [31:0] field_value;
   } req_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic [1:0]  word_kind;
      logic        last_word;
   } rsp_type;

   // mask store access strobes
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } mask_ctl_type;

endpackage

// ===== src/sfms_mask_store.sv =====
// ----------------------------------------------------------------------------
// sfms_mask_store
// Bitmap of marked fields, one 32-bit word per block. Synchronous memory with
// a per-word valid bit (a word not yet written reads as zero), a clear of
// all valid bits, and a running count of blocks up to the highest nonzero
// word.
// ----------------------------------------------------------------------------
module sfms_mask_store #(
   parameter int WORDS = 40,
   parameter int AW    = 6,
   parameter int CW    = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfms_pkg::mask_ctl_type ctl,
   input  logic [AW-1:0]         rd_addr,
   input  logic [AW-1:0]         wr_addr,
   input  logic [31:0]           wr_data,
   output logic [31:0]           rd_data,
   output logic [CW-1:0]         block_count
);

   logic [31:0]      mem [WORDS];
   logic [WORDS-1:0] valid_ff;
   logic [WORDS-1:0] valid_in;
   logic [31:0]      rd_q_ff;
   logic             rd_valid_ff;
   logic [CW-1:0]    blocks_ff;
   logic [CW-1:0]    blocks_in;
   logic [CW-1:0]    wr_count;

   // words are only ever written with a freshly set bit, so valid means nonzero
   assign wr_count = CW'(wr_addr) + CW'(1);

   always_comb begin
      valid_in  = valid_ff;
      blocks_in = blocks_ff;
      if (ctl.clear) begin
         valid_in  = '0;
         blocks_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
         if (wr_count > blocks_ff) begin
            blocks_in = wr_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         blocks_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         blocks_ff <= blocks_in;
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // memory array
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign rd_data     = rd_valid_ff ? rd_q_ff : '0;
   assign block_count = blocks_ff;

   // checks
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (blocks_ff == '0) && (valid_ff == '0))
      else $error("mask store not empty after clear");

   a_write_marks: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_en && !ctl.clear) |=> valid_ff[$past(wr_addr)] && (blocks_ff != '0))
      else $error("written mask word not marked valid");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      blocks_ff <= CW'(WORDS))
      else $error("block count beyond mask depth");

endmodule

// ===== src/sparse_field_mask_serializer.sv =====
// ----------------------------------------------------------------------------
// sparse_field_mask_serializer
// Field value table with a set-bit mask, serialized one word per read command.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; a read answers with
// one beat on rsp_strobe/rsp_item that cannot be stalled. A set of a field in
// range does a read-modify-write of its mask word, writing it in S_SET_WR; a
// clear and a set outside the range leave busy low. A read of the block count
// answers in the next cycle; a mask word read answers through the mask store
// read register and S_MASK_OUT; a field value read searches the bitmap in
// S_SCAN, skipping empty mask words, one mask word per cycle through the
// single read port of the mask memory, then reads the value in S_VAL_RD and
// answers from S_VAL_OUT. Values live in a FIELD_COUNT-entry synchronous
// memory; a value is only ever read for a field that a set has marked.
// ----------------------------------------------------------------------------
module sparse_field_mask_serializer #(
   parameter int FIELD_COUNT = 1280
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sfms_pkg::req_type req_item,
   output logic              rsp_strobe,
   output sfms_pkg::rsp_type rsp_item
);

   localparam int MASK_WORDS = (FIELD_COUNT + 31) / 32;
   localparam int MW_AW      = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
   localparam int HB_W       = $clog2(MASK_WORDS + 1);
   localparam int FA         = $clog2(FIELD_COUNT);

   localparam logic [1:0] PH_COUNT = 2'd0;
   localparam logic [1:0] PH_MASK  = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SET_WR,
      S_MASK_OUT,
      S_SCAN,
      S_VAL_RD,
      S_VAL_OUT
   } state_type;

   // lowest set bit of a word
   function automatic logic [4:0] lowest_bit(input logic [31:0] w);
      logic [4:0] pos;
      pos = '0;
      for (int i = 31; i >= 0; i--) begin
         if (w[i]) begin
            pos = 5'(i);
         end
      end
      return pos;
   endfunction

   state_type         state_ff;
   logic [1:0]        phase_ff;
   logic [HB_W-1:0]   hb_ff;
   logic [HB_W-1:0]   mw_cur_ff;
   logic [HB_W-1:0]   fld_word_ff;
   logic [4:0]        fld_bit_ff;
   logic [HB_W-1:0]   scan_word_ff;
   logic [4:0]        scan_low_ff;
   logic [HB_W-1:0]   f_word_ff;
   logic [4:0]        f_bit_ff;
   logic              f_last_ff;
   logic [MW_AW-1:0]  set_word_ff;
   logic [4:0]        set_bit_ff;
   logic [31:0]       fs_q_ff;
   logic              rsp_strobe_ff;
   sfms_pkg::rsp_type rsp_ff;
   logic [31:0]       field_mem [FIELD_COUNT];

   sfms_pkg::mask_ctl_type mask_ctl;
   logic [MW_AW-1:0]  mask_rd_addr;
   logic [31:0]       mask_wr_data;
   logic [31:0]       mask_rd_data;
   logic [HB_W-1:0]   live_blocks;

   logic              accept;
   logic              set_in_range;
   logic [MW_AW-1:0]  req_word;
   logic [31:0]       scan_bits;
   logic              scan_hit;
   logic [4:0]        scan_pos;
   logic              scan_last;
   logic              scan_end;
   logic [HB_W:0]     scan_next;
   logic [HB_W:0]     mw_next;
   logic [FA-1:0]     f_addr;

   assign accept       = start && !busy;
   assign set_in_range = {1'b0, req_item.field_index} < 12'(FIELD_COUNT);
   assign req_word     = req_item.field_index[5 +: MW_AW];

   // bitmap search over the current mask word
   assign scan_bits = mask_rd_data & (32'hFFFF_FFFF << scan_low_ff);
   assign scan_hit  = |scan_bits;
   assign scan_pos  = lowest_bit(scan_bits);
   assign scan_next = {1'b0, scan_word_ff} + (HB_W + 1)'(1);
   assign scan_end  = scan_next >= {1'b0, hb_ff};
   assign scan_last = ((scan_bits & (scan_bits - 32'd1)) == '0) &&
                      (scan_next == {1'b0, hb_ff});
   assign mw_next   = {1'b0, mw_cur_ff} + (HB_W + 1)'(1);
   assign f_addr    = FA'({f_word_ff, f_bit_ff});

   assign mask_wr_data = mask_rd_data | (32'd1 << set_bit_ff);

   // mask store access
   always_comb begin
      mask_ctl     = '0;
      mask_rd_addr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_item.cmd == sfms_pkg::CMD_SET && set_in_range) begin
               mask_ctl.rd_en = 1'b1;
               mask_rd_addr   = req_word;
            end else if (accept && req_item.cmd == sfms_pkg::CMD_CLEAR) begin
               mask_ctl.clear = 1'b1;
            end else if (accept && req_item.cmd == sfms_pkg::CMD_READ) begin
               if (phase_ff == PH_MASK) begin
                  mask_ctl.rd_en = 1'b1;
                  mask_rd_addr   = mw_cur_ff[MW_AW-1:0];
               end else if (phase_ff == PH_VALUE) begin
                  mask_ctl.rd_en = 1'b1;
                  mask_rd_addr   = fld_word_ff[MW_AW-1:0];
               end
            end
         end
         S_SET_WR: begin
            mask_ctl.wr_en = 1'b1;
         end
         S_SCAN: begin
            if (!scan_hit && !scan_end) begin
               mask_ctl.rd_en = 1'b1;
               mask_rd_addr   = scan_next[MW_AW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   sfms_mask_store #(
      .WORDS(MASK_WORDS),
      .AW   (MW_AW),
      .CW   (HB_W)
   ) u_mask (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mask_ctl),
      .rd_addr    (mask_rd_addr),
      .wr_addr    (set_word_ff),
      .wr_data    (mask_wr_data),
      .rd_data    (mask_rd_data),
      .block_count(live_blocks)
   );

   // field value memory
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept && req_item.cmd == sfms_pkg::CMD_SET &&
          set_in_range) begin
         field_mem[req_item.field_index[FA-1:0]] <= req_item.field_value;
      end
      if (state_ff == S_VAL_RD) begin
         fs_q_ff <= field_mem[f_addr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_COUNT;
         hb_ff         <= '0;
         mw_cur_ff     <= '0;
         fld_word_ff   <= '0;
         fld_bit_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_item.cmd) inside
                     sfms_pkg::CMD_SET, sfms_pkg::CMD_CLEAR: begin
                        phase_ff    <= PH_COUNT;
                        mw_cur_ff   <= '0;
                        fld_word_ff <= '0;
                        fld_bit_ff  <= '0;
                        if (req_item.cmd == sfms_pkg::CMD_SET && set_in_range) begin
                           set_word_ff <= req_word;
                           set_bit_ff  <= req_item.field_index[4:0];
                           state_ff    <= S_SET_WR;
                        end
                     end
                     sfms_pkg::CMD_READ: begin
                        case (phase_ff) inside
                           PH_MASK: begin
                              state_ff <= S_MASK_OUT;
                           end
                           PH_VALUE: begin
                              scan_word_ff <= fld_word_ff;
                              scan_low_ff  <= fld_bit_ff;
                              state_ff     <= S_SCAN;
                           end
                           default: begin
                              // block count word
                              hb_ff              <= live_blocks;
                              mw_cur_ff          <= '0;
                              phase_ff           <= (live_blocks == '0) ? PH_COUNT : PH_MASK;
                              rsp_strobe_ff      <= 1'b1;
                              rsp_ff.out_word    <= 32'(live_blocks);
                              rsp_ff.word_kind   <= sfms_pkg::KIND_COUNT;
                              rsp_ff.last_word   <= (live_blocks == '0);
                           end
                        endcase
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SET_WR: begin
               state_ff <= S_IDLE;
            end
            S_MASK_OUT: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_ff.out_word  <= mask_rd_data;
               rsp_ff.word_kind <= sfms_pkg::KIND_MASK;
               rsp_ff.last_word <= 1'b0;
               if (mw_next >= {1'b0, hb_ff}) begin
                  phase_ff    <= PH_VALUE;
                  mw_cur_ff   <= '0;
                  fld_word_ff <= '0;
                  fld_bit_ff  <= '0;
               end else begin
                  mw_cur_ff <= mw_next[HB_W-1:0];
               end
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               if (scan_hit) begin
                  f_word_ff <= scan_word_ff;
                  f_bit_ff  <= scan_pos;
                  f_last_ff <= scan_last;
                  state_ff  <= S_VAL_RD;
               end else if (scan_end) begin
                  // position lost: restart with the block count
                  hb_ff            <= live_blocks;
                  mw_cur_ff        <= '0;
                  fld_word_ff      <= '0;
                  fld_bit_ff       <= '0;
                  phase_ff         <= (live_blocks == '0) ? PH_COUNT : PH_MASK;
                  rsp_strobe_ff    <= 1'b1;
                  rsp_ff.out_word  <= 32'(live_blocks);
                  rsp_ff.word_kind <= sfms_pkg::KIND_COUNT;
                  rsp_ff.last_word <= (live_blocks == '0);
                  state_ff         <= S_IDLE;
               end else begin
                  scan_word_ff <= scan_next[HB_W-1:0];
                  scan_low_ff  <= '0;
               end
            end
            S_VAL_RD: begin
               state_ff <= S_VAL_OUT;
            end
            S_VAL_OUT: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_ff.out_word  <= fs_q_ff;
               rsp_ff.word_kind <= sfms_pkg::KIND_VALUE;
               rsp_ff.last_word <= f_last_ff;
               if (f_last_ff) begin
                  phase_ff    <= PH_COUNT;
                  fld_word_ff <= '0;
                  fld_bit_ff  <= '0;
               end else if (f_bit_ff == 5'd31) begin
                  fld_word_ff <= f_word_ff + HB_W'(1);
                  fld_bit_ff  <= '0;
               end else begin
                  fld_word_ff <= f_word_ff;
                  fld_bit_ff  <= f_bit_ff + 5'd1;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // checks
   a_no_rsp_for_write: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.cmd != sfms_pkg::CMD_READ) |=> !rsp_strobe)
      else $error("response beat after a set or clear");

   a_empty_count_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.word_kind == sfms_pkg::KIND_COUNT && rsp_item.last_word)
      |-> (rsp_item.out_word == '0))
      else $error("nonzero block count flagged as last");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last_word) |-> (phase_ff == PH_COUNT))
      else $error("reading did not restart after last word");

   a_mask_phase_blocks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MASK || phase_ff == PH_VALUE) |-> (hb_ff != '0))
      else $error("mask or value phase with no blocks");

endmodule
